@@ src/u8sd_pkg.sv @@
// Shared types and constants for the UTF-8 stream decoder.
// Holds the lead-byte classification record and the result record.
// No dependencies.
`default_nettype none

package u8sd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CP_W      = 31;
    localparam int unsigned LEN_W     = 3;
    localparam int unsigned PAYLOAD_W = 7;
    localparam int unsigned CONT_W    = 6;

    // Sequence lengths
    localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;
    localparam logic [LEN_W-1:0] LEN_FIVE  = 3'd5;
    localparam logic [LEN_W-1:0] LEN_SIX   = 3'd6;

    // Classification of a byte seen where a lead byte is expected
    typedef struct packed {
        logic                 single;   // 7-bit character, done in one byte
        logic                 bad;      // stray continuation or 0xFE/0xFF
        logic [LEN_W-1:0]     len;      // total sequence length
        logic [PAYLOAD_W-1:0] payload;  // lead payload bits
    } t_lead_info;

    // One decoded result
    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] seq_length;
        logic             bad_lead;
    } t_result;

endpackage

`default_nettype wire

@@ src/u8sd_lead_decode.sv @@
// Lead-byte classifier for the UTF-8 stream decoder.
// Maps a raw byte to its sequence length and payload bits.
// Depends on u8sd_pkg.
`default_nettype none

module u8sd_lead_decode (
    input  wire logic [u8sd_pkg::BYTE_W-1:0] i_byte,
    output u8sd_pkg::t_lead_info             o_info
);
    import u8sd_pkg::*;

    // Match the byte against the lead patterns, longest prefix last
    always_comb begin
        o_info = '0;
        case (i_byte) inside
            8'b0???????: begin
                o_info.single  = 1'b1;
                o_info.len     = LEN_ONE;
                o_info.payload = i_byte[6:0];
            end
            8'b110?????: begin
                o_info.len     = LEN_TWO;
                o_info.payload = {2'b00, i_byte[4:0]};
            end
            8'b1110????: begin
                o_info.len     = LEN_THREE;
                o_info.payload = {3'b000, i_byte[3:0]};
            end
            8'b11110???: begin
                o_info.len     = LEN_FOUR;
                o_info.payload = {4'b0000, i_byte[2:0]};
            end
            8'b111110??: begin
                o_info.len     = LEN_FIVE;
                o_info.payload = {5'b00000, i_byte[1:0]};
            end
            8'b1111110?: begin
                o_info.len     = LEN_SIX;
                o_info.payload = {6'b000000, i_byte[0]};
            end
            default: begin
                // stray continuation byte or 0xFE/0xFF
                o_info.bad = 1'b1;
                o_info.len = LEN_ONE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/u8sd_seq_state.sv @@
// Sequence tracker for the UTF-8 stream decoder.
// Holds the remaining count, accumulator and length; forms each result.
// Depends on u8sd_pkg and u8sd_lead_decode.
`default_nettype none

module u8sd_seq_state (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire logic [u8sd_pkg::BYTE_W-1:0] i_byte,
    output logic                             o_res_vld,
    output u8sd_pkg::t_result                o_res
);
    import u8sd_pkg::*;

    t_lead_info lead;

    logic [LEN_W-1:0] r_bytes_left;
    logic [LEN_W-1:0] n_bytes_left;
    logic [CP_W-1:0]  r_accum;
    logic [CP_W-1:0]  n_accum;
    logic [LEN_W-1:0] r_seq_len;
    logic [LEN_W-1:0] n_seq_len;
    logic [CP_W-1:0]  shifted;

    u8sd_lead_decode u_lead (
        .i_byte (i_byte),
        .o_info (lead)
    );

    assign shifted = {r_accum[CP_W-CONT_W-1:0], i_byte[CONT_W-1:0]};

    // Work out next state and the result of this byte
    always_comb begin
        n_bytes_left = r_bytes_left;
        n_accum      = r_accum;
        n_seq_len    = r_seq_len;
        o_res_vld    = 1'b0;
        o_res        = '0;
        if (r_bytes_left != '0) begin
            // continuation: top bits are not checked
            n_bytes_left = r_bytes_left - LEN_W'(1);
            n_accum      = shifted;
            if (r_bytes_left == LEN_W'(1)) begin
                o_res_vld         = 1'b1;
                o_res.code_point  = shifted;
                o_res.seq_length  = r_seq_len;
                n_accum           = '0;
                n_seq_len         = '0;
            end
        end else if (lead.single || lead.bad) begin
            o_res_vld        = 1'b1;
            o_res.code_point = lead.bad ? '0 : CP_W'(lead.payload);
            o_res.seq_length = LEN_ONE;
            o_res.bad_lead   = lead.bad;
        end else begin
            // seed a multi-byte sequence
            n_accum      = CP_W'(lead.payload);
            n_seq_len    = lead.len;
            n_bytes_left = lead.len - LEN_W'(1);
        end
    end

    // Advance state on each processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
            r_accum      <= '0;
            r_seq_len    <= '0;
        end else if (i_step) begin
            r_bytes_left <= n_bytes_left;
            r_accum      <= n_accum;
            r_seq_len    <= n_seq_len;
        end
    end

endmodule

`default_nettype wire

@@ src/utf8_stream_decoder_core.sv @@
// Top level of the UTF-8 stream decoder: input register, sequence
// tracker and output register with valid/stall handshakes.
// Depends on u8sd_pkg and u8sd_seq_state.
//
// Decodes a UTF-8 byte stream (original 1 to 6 byte forms) at one byte per
// clock cycle, sustained while no stall holds it. Each byte is taken into an
// input register, passes through the lead classifier and the one-step
// accumulator, and lands in an output register, from which the result of
// the byte that ends a sequence drives o_valid. Bytes that only open or
// continue a sequence produce nothing. The single accumulate step per byte
// sets the rate. A stray continuation byte or a 0xFE/0xFF lead yields code
// point 0, length 1, with o_bad_lead set. Inside a sequence every byte is
// taken as a continuation and only its low six bits count. i_stall from the
// consumer holds the output register and, while a byte waits behind it,
// raises o_stall toward the producer.
`default_nettype none

module utf8_stream_decoder_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // byte input channel
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [u8sd_pkg::BYTE_W-1:0]   i_in_byte,
    // result output channel
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [u8sd_pkg::CP_W-1:0]          o_code_point,
    output logic [u8sd_pkg::LEN_W-1:0]         o_seq_length,
    output logic                               o_bad_lead
);
    import u8sd_pkg::*;

    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_vld;
    t_result           r_out;
    logic              out_free;
    logic              step;
    logic              res_vld;
    t_result           res;

    assign out_free = !r_out_vld || !i_stall;
    assign step     = r_in_vld && out_free;
    assign o_stall  = r_in_vld && !out_free;

    // Capture the incoming byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

    u8sd_seq_state u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_byte    (r_in_byte),
        .o_res_vld (res_vld),
        .o_res     (res)
    );

    // Hold or refill the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= step && res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && step && res_vld) begin
            r_out <= res;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_code_point = r_out.code_point;
    assign o_seq_length = r_out.seq_length;
    assign o_bad_lead   = r_out.bad_lead;

endmodule

`default_nettype wire

@@ src/u8sd_checker.sv @@
// Port-level checker for the UTF-8 stream decoder, bound to the top level.
// Watches the result channel for legal and consistent transactions.
// Depends on u8sd_pkg and utf8_stream_decoder_core.
`default_nettype none

module u8sd_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          o_valid,
    input  wire logic                          i_stall,
    input  wire logic [u8sd_pkg::CP_W-1:0]     o_code_point,
    input  wire logic [u8sd_pkg::LEN_W-1:0]    o_seq_length,
    input  wire logic                          o_bad_lead
);
    import u8sd_pkg::*;

    // Hold a stalled result transaction
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_code_point)
            && $stable(o_seq_length) && $stable(o_bad_lead))
        else $error("stalled result changed");

    // Length stays in the legal range
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_seq_length >= LEN_ONE && o_seq_length <= LEN_SIX)
        else $error("sequence length out of range");

    // Bad lead gives code point zero over one byte
    a_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_lead |-> o_code_point == '0 && o_seq_length == LEN_ONE)
        else $error("bad lead result malformed");

    // Single byte results are 7-bit characters
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_seq_length == LEN_ONE |-> o_code_point < CP_W'(128))
        else $error("single byte code point too wide");

    // Two byte results carry at most 11 bits
    a_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_seq_length == LEN_TWO |-> o_code_point < CP_W'(2048) && !o_bad_lead)
        else $error("two byte result malformed");

endmodule

bind utf8_stream_decoder_core u8sd_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_code_point (o_code_point),
    .o_seq_length (o_seq_length),
    .o_bad_lead   (o_bad_lead)
);

`default_nettype wire

@@ tb/sv/tb_utf8_stream_decoder_checker.sv @@
`timescale 1ns / 100ps
// Checker for the UTF-8 stream decoder: watches both channels, predicts each
// decoded code point and compares it with the block's output transactions.
// Depends on u8sd_pkg.

module tb_utf8_stream_decoder_checker
    import u8sd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [BYTE_W-1:0] i_in_byte,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [CP_W-1:0]   i_code_point,
    input  logic [LEN_W-1:0]  i_seq_length,
    input  logic              i_bad_lead,
    output int                o_fail_count,
    output int                o_results_due
);

    // Decoder state as the predictor sees it
    logic [LEN_W-1:0] cont_left;
    logic [CP_W-1:0]  cp_acc;
    logic [LEN_W-1:0] lead_len;
    t_result          decoded_q[$];

    // Advance the predicted decoder by one byte; return 1 when a code point completes
    function automatic bit decode_byte(input logic [BYTE_W-1:0] b, output t_result res);
        logic [PAYLOAD_W-1:0] seed;
        logic [LEN_W-1:0]     len;
        bit                   produced;
        produced = 1'b0;
        res = '0;
        seed = '0;
        len = '0;
        if (cont_left != '0) begin
            // inside a sequence every byte counts, top bits unchecked
            cp_acc = {cp_acc[CP_W-CONT_W-1:0], b[CONT_W-1:0]};
            cont_left = cont_left - 1'b1;
            if (cont_left == '0) begin
                res.code_point = cp_acc;
                res.seq_length = lead_len;
                res.bad_lead = 1'b0;
                cp_acc = '0;
                lead_len = '0;
                produced = 1'b1;
            end
        end else begin
            casez (b)
                8'b0???????: len = LEN_ONE;
                8'b110?????: begin len = LEN_TWO;   seed = PAYLOAD_W'(b[4:0]); end
                8'b1110????: begin len = LEN_THREE; seed = PAYLOAD_W'(b[3:0]); end
                8'b11110???: begin len = LEN_FOUR;  seed = PAYLOAD_W'(b[2:0]); end
                8'b111110??: begin len = LEN_FIVE;  seed = PAYLOAD_W'(b[1:0]); end
                8'b1111110?: begin len = LEN_SIX;   seed = PAYLOAD_W'(b[0]);   end
                default:     len = '0;
            endcase
            if (len == LEN_ONE) begin
                res.code_point = CP_W'(b);
                res.seq_length = LEN_ONE;
                produced = 1'b1;
            end else if (len == '0) begin
                // stray continuation or 0xFE/0xFF lead
                res.seq_length = LEN_ONE;
                res.bad_lead = 1'b1;
                produced = 1'b1;
            end else begin
                cp_acc = CP_W'(seed);
                lead_len = len;
                cont_left = len - 1'b1;
            end
        end
        return produced;
    endfunction

    // Compare output transactions, then queue predictions for input transactions
    always @(posedge i_clk) begin : check_proc
        t_result want;
        t_result pred;
        if (!i_rst_n) begin
            cont_left = '0;
            cp_acc = '0;
            lead_len = '0;
            decoded_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected result: code_point %0h seq_length %0d bad_lead %0b",
                           i_code_point, i_seq_length, i_bad_lead);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = decoded_q.pop_front();
                    if (i_code_point !== want.code_point) begin
                        $error("code_point: expected %0h, got %0h",
                               want.code_point, i_code_point);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_seq_length !== want.seq_length) begin
                        $error("seq_length: expected %0d, got %0d",
                               want.seq_length, i_seq_length);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_bad_lead !== want.bad_lead) begin
                        $error("bad_lead: expected %0b, got %0b",
                               want.bad_lead, i_bad_lead);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (decode_byte(i_in_byte, pred))
                    decoded_q.push_back(pred);
            end
        end
        o_results_due = decoded_q.size();
    end

endmodule

@@ tb/sv/tb_utf8_stream_decoder_core.sv @@
`timescale 1ns / 100ps
// Top of the UTF-8 stream decoder testbench: clock, reset, byte stimulus,
// result-side stall and the verdict. Depends on u8sd_pkg, the decoder core
// and tb_utf8_stream_decoder_checker.

module tb_utf8_stream_decoder_core;
    import u8sd_pkg::*;

    localparam int BYTES_PER_PHASE = 290;
    localparam int NUM_PHASES      = 5;
    localparam int HOLD_CYCLES     = 150;
    localparam int IDLE_LIMIT      = 2000;
    localparam int TAIL_CYCLES     = 8;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [BYTE_W-1:0] i_in_byte;
    logic              o_valid;
    logic              i_stall;
    logic [CP_W-1:0]   o_code_point;
    logic [LEN_W-1:0]  o_seq_length;
    logic              o_bad_lead;

    int fail_count;
    int results_due;
    int bytes_sent = 0;
    int idle_cycles = 0;
    bit src_gaps_en = 1'b0;
    bit sink_gaps_en = 1'b0;
    bit hold_req = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    utf8_stream_decoder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_byte   (i_in_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_code_point(o_code_point),
        .o_seq_length(o_seq_length),
        .o_bad_lead  (o_bad_lead)
    );

    tb_utf8_stream_decoder_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_byte    (i_in_byte),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_code_point (o_code_point),
        .i_seq_length (o_seq_length),
        .i_bad_lead   (o_bad_lead),
        .o_fail_count (fail_count),
        .o_results_due(results_due)
    );

    // Mostly short stretches, now and then a long one
    function automatic int stretch_len();
        if ($urandom_range(0, 9) < 9)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // Offer one byte and hold it until the transaction completes
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = (src_gaps_en && $urandom_range(0, 1)) ? stretch_len() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_in_byte <= b;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
    endtask

    // Drop valid and wait for every predicted code point to arrive
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (results_due != 0) @(posedge i_clk);
    endtask

    // Send one sequence: mostly well formed, some noise and unchecked continuations
    task automatic send_sequence();
        int kind;
        int len;
        logic [BYTE_W-1:0] lead;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            send_byte(BYTE_W'($urandom));
        end else begin
            len = $urandom_range(1, 6);
            case (len)
                1:       lead = {1'b0, 7'($urandom)};
                2:       lead = {3'b110, 5'($urandom)};
                3:       lead = {4'b1110, 4'($urandom)};
                4:       lead = {5'b11110, 3'($urandom)};
                5:       lead = {6'b111110, 2'($urandom)};
                default: lead = {7'b1111110, 1'($urandom)};
            endcase
            send_byte(lead);
            for (int i = 1; i < len; i++) begin
                if (kind < 20)
                    send_byte(BYTE_W'($urandom));
                else
                    send_byte({2'b10, 6'($urandom)});
            end
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (sink_gaps_en && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat (stretch_len() - 1) @(negedge i_clk);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: count cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stimulus
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_in_byte = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single-byte extremes
        send_byte(8'h00); send_byte(8'h7F);
        // stray continuations and 0xFE/0xFF leads
        send_byte(8'h80); send_byte(8'hBF); send_byte(8'hFE); send_byte(8'hFF);
        // two-byte form with a lead-like byte as continuation (unchecked top bits)
        send_byte(8'hDF); send_byte(8'hFF);
        // three- and four-byte maxima
        send_byte(8'hEF); send_byte(8'hBF); send_byte(8'hBF);
        send_byte(8'hF7); send_byte(8'hBF); send_byte(8'hBF); send_byte(8'hBF);
        // five-byte minimum payload
        send_byte(8'hF8); send_byte(8'h80); send_byte(8'h80);
        send_byte(8'h80); send_byte(8'h80);
        // six-byte form filling all 31 bits
        send_byte(8'hFD); send_byte(8'hBF); send_byte(8'hBF);
        send_byte(8'hBF); send_byte(8'hBF); send_byte(8'hBF);
        drain_results();

        // random phases with different idling; phase 2 holds the result side off
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            src_gaps_en = (phase == 1) || (phase == 3) || (phase == 4);
            sink_gaps_en = (phase == 1) || (phase == 4);
            if (phase == 2)
                hold_req = 1'b1;
            while (bytes_sent < 25 + (phase + 1) * BYTES_PER_PHASE)
                send_sequence();
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ utf8_stream_decoder_core.f @@
src/u8sd_pkg.sv
src/u8sd_lead_decode.sv
src/u8sd_seq_state.sv
src/utf8_stream_decoder_core.sv
src/u8sd_checker.sv
tb/sv/tb_utf8_stream_decoder_checker.sv
tb/sv/tb_utf8_stream_decoder_core.sv
